FILE: src/assert_macros.svh
// Assertion macros shared by the sanitizer modules.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define USN_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Precondition this cycle implies a consequence in the next cycle.
`define USN_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("%m: assertion failed");

`endif

FILE: src/usn_pkg.sv
// Package for the UTF-8 stream sanitizer: payload structs, job type, constants.
// No dependencies; all sanitizer modules refer to it by scoped names.
package usn_pkg;

  // Input transfer payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  // Output transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;
    logic       string_last;
  } out_item_t;

  localparam int unsigned MaxResults = 4;

  // One input byte's worth of output, handed from front to back
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [MaxResults-1:0]      rep;
    logic [1:0]                 last_idx;
    logic                       str_last;
  } job_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ReplReset  = 8'h3F; // '?'
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContVal    = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Val   = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Val   = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Val   = 8'hF0;

  // Continuation bytes a lead asks for; 0 for anything that is not a multi-byte lead
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] need;
    need = 2'd0;
    if ((b & Lead2Mask) == Lead2Val) begin
      need = 2'd1;
    end else if ((b & Lead3Mask) == Lead3Val) begin
      need = 2'd2;
    end else if ((b & Lead4Mask) == Lead4Val) begin
      need = 2'd3;
    end
    return need;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContVal;
  endfunction

endpackage

FILE: src/usn_front.sv
// Sanitizer front end: takes input bytes, tracks the pending sequence, emits jobs.
// Depends on usn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       repl_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  usn_pkg::in_item_t in_data_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output usn_pkg::job_t    job_o
);

  logic [7:0] held_q [3];
  logic [7:0] held_d [3];
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [1:0] need_q, need_d;

  logic [7:0] b;
  logic       str_end;
  logic       cont;
  logic [1:0] need_new;
  logic [1:0] pre_cnt;
  logic       pre_rep;
  logic       tail_en;
  logic [7:0] tail_byte;
  logic       tail_rep;
  logic       ended;
  logic [2:0] res_cnt;
  logic       accept;

  assign b        = in_data_i.in_byte;
  assign str_end  = in_data_i.string_end;
  assign cont     = usn_pkg::is_cont(b);
  assign need_new = usn_pkg::lead_need(b);

  // Results are a prefix of held bytes (as-is or replaced) and at most one tail byte
  always_comb begin
    held_d     = held_q;
    held_cnt_d = held_cnt_q;
    need_d     = need_q;
    pre_cnt    = 2'd0;
    pre_rep    = 1'b0;
    tail_en    = 1'b0;
    tail_byte  = b;
    tail_rep   = 1'b0;
    ended      = str_end;
    if (held_cnt_q != 2'd0 && cont) begin
      if (need_q <= 2'd1 || held_cnt_q == 2'd3) begin
        // sequence complete
        pre_cnt    = held_cnt_q;
        tail_en    = 1'b1;
        held_cnt_d = 2'd0;
        need_d     = 2'd0;
      end else if (str_end) begin
        // truncated by string end
        pre_cnt    = held_cnt_q;
        pre_rep    = 1'b1;
        tail_en    = 1'b1;
        tail_byte  = repl_i;
        tail_rep   = 1'b1;
        held_cnt_d = 2'd0;
        need_d     = 2'd0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) == held_cnt_q) begin
            held_d[i] = b;
          end
        end
        held_cnt_d = held_cnt_q + 2'd1;
        need_d     = need_q - 2'd1;
      end
    end else begin
      // anything pending is broken; this byte starts afresh
      pre_cnt    = held_cnt_q;
      pre_rep    = 1'b1;
      held_cnt_d = 2'd0;
      need_d     = 2'd0;
      if (b == 8'd0) begin
        tail_en = 1'b1;
        ended   = 1'b1;
      end else if (!b[7]) begin
        tail_en = 1'b1;
      end else if (need_new != 2'd0) begin
        if (str_end) begin
          tail_en   = 1'b1;
          tail_byte = repl_i;
          tail_rep  = 1'b1;
        end else begin
          held_d[0]  = b;
          held_cnt_d = 2'd1;
          need_d     = need_new;
        end
      end else begin
        tail_en   = 1'b1;
        tail_byte = repl_i;
        tail_rep  = 1'b1;
      end
    end
  end

  assign res_cnt = {1'b0, pre_cnt} + {2'b00, tail_en};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < pre_cnt) begin
        job_o.bytes[i] = pre_rep ? repl_i : held_q[i];
        job_o.rep[i]   = pre_rep;
      end else begin
        job_o.bytes[i] = tail_byte;
        job_o.rep[i]   = tail_rep;
      end
    end
    job_o.bytes[3]  = tail_byte;
    job_o.rep[3]    = tail_rep;
    job_o.last_idx  = 2'(res_cnt - 3'd1);
    job_o.str_last  = ended;
  end

  assign job_valid_o     = in_valid_i && (res_cnt != 3'd0);
  assign in_ready_o      = job_ready_i;
  assign accept          = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      need_q     <= 2'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      need_q     <= need_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

  `USN_ASSERT(a_idle_no_need, (held_cnt_q != 2'd0) || (need_q == 2'd0))
  `USN_ASSERT(a_full_needs_one, (held_cnt_q != 2'd3) || (need_q == 2'd1))
  `USN_ASSERT(a_seq_len, ({1'b0, held_cnt_q} + {1'b0, need_q}) <= 3'd4)

endmodule

FILE: src/usn_queue.sv
// Short job queue between sanitizer front and back ends.
// Depends on usn_pkg for the job type and depth.
module usn_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  usn_pkg::job_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output usn_pkg::job_t pop_data_o
);

  localparam int unsigned Depth = usn_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  usn_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/usn_back.sv
// Sanitizer back end: holds one job and sends its bytes one per cycle while out_ready_i is high.
// Depends on usn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usn_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  usn_pkg::job_t      job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output usn_pkg::out_item_t out_data_o
);

  usn_pkg::job_t job_q;
  logic          busy_q;
  logic [1:0]    idx_q;
  logic          last;
  logic          out_xfer;
  logic          load;

  assign last        = idx_q == job_q.last_idx;
  assign out_xfer    = out_valid_o && out_ready_i;
  assign job_ready_o = !busy_q || (out_ready_i && last);
  assign load        = job_valid_i && job_ready_o;
  assign out_valid_o = busy_q;

  assign out_data_o.out_byte     = job_q.bytes[idx_q];
  assign out_data_o.was_replaced = job_q.rep[idx_q];
  assign out_data_o.run_last     = last;
  assign out_data_o.string_last  = last && job_q.str_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (out_xfer) begin
      if (last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
  end

  `USN_ASSERT(a_idx_in_job, !busy_q || (idx_q <= job_q.last_idx))
  `USN_ASSERT_NEXT(a_stall_holds, busy_q && !out_ready_i, busy_q && $stable(idx_q))
  `USN_ASSERT_NEXT(a_step_on, out_xfer && !last, busy_q && (idx_q == $past(idx_q) + 2'd1))

endmodule

FILE: src/utf8_stream_sanitizer.sv
// UTF-8 stream sanitizer. Bytes of a string enter on the in channel, one per
// transfer, and the same number of bytes leave on the out channel in order.
// A lead byte (110xxxxx, 1110xxxx, 11110xxx) is held with its continuation
// bytes until the sequence is complete, then all go out unchanged. A bad lead
// or stray continuation becomes the replacement byte; a sequence cut short by
// a non-continuation byte goes out as replacement bytes and the breaking byte
// is handled afresh. string_end or a zero byte closes the string: any incomplete
// sequence is replaced and the last output carries string_last. Input that only
// extends a pending sequence gives no output at once. Overlong forms and
// surrogates pass unchecked. Rate: one input byte per cycle while the queue has
// room; the output side sends one byte per cycle while out_ready_i is high, an
// input releases up to 4 bytes, and a two-entry job queue lets input run on
// meanwhile. A job is registered in the queue and again in the back end before
// output. The replacement byte (reset '?') is written through the cfg channel,
// always ready, and must only change while no bytes are in flight.
// Depends on usn_pkg, usn_front, usn_queue and usn_back.
module utf8_stream_sanitizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  usn_pkg::in_item_t  in_data_i,
  // sanitized output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output usn_pkg::out_item_t out_data_o,
  // replacement byte write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  logic [7:0] repl_q;

  logic          fq_valid, fq_ready;
  usn_pkg::job_t fq_job;
  logic          qb_valid, qb_ready;
  usn_pkg::job_t qb_job;

  // config register, written on any cfg transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= usn_pkg::ReplReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      repl_q <= cfg_data_i;
    end
  end

  // front: classify byte, update pending sequence, build the job
  usn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .repl_i      (repl_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  // decoupling queue
  usn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_job)
  );

  // back: serialise job bytes onto the output
  usn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
